// ===== rtl/lrukc_pkg.sv =====
`timescale 1ns / 1ps

package lrukc_pkg;

    localparam int ENTRIES = 16;
    localparam int SLOT_W  = $clog2(ENTRIES);
    localparam int RANK_W  = $clog2(ENTRIES);
    localparam int FILL_W  = $clog2(ENTRIES + 1);
    localparam int LAT_W   = 8;
    localparam int LON_W   = 9;
    localparam int CAP_W   = 5;
    localparam int MISS_W  = 32;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // lookup context broadcast to every cell
    typedef struct packed {
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
        logic [FILL_W-1:0]       fill;
        logic [RANK_W-1:0]       last_rank;
    } look_t;

    // update command broadcast to every cell
    typedef struct packed {
        logic                    en;
        logic                    write;
        logic [SLOT_W-1:0]       slot;
        logic [RANK_W-1:0]       old_rank;
        logic signed [LAT_W-1:0] lat;
        logic signed [LON_W-1:0] lon;
    } upd_t;

    // accumulated match and victim info handed from cell to cell
    typedef struct packed {
        logic                    hit;
        logic [SLOT_W-1:0]       hit_slot;
        logic [RANK_W-1:0]       hit_rank;
        logic [SLOT_W-1:0]       vic_slot;
        logic signed [LAT_W-1:0] vic_lat;
        logic signed [LON_W-1:0] vic_lon;
    } chain_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_LOOK = 2'b10
    } state_t;

endpackage

// ===== rtl/lrukc_if.sv =====
`timescale 1ns / 1ps

interface lrukc_key_if import lrukc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] key_lat;
    logic signed [LON_W-1:0] key_lon;

    modport source (output valid, output key_lat, output key_lon, input ready);
    modport sink   (input valid, input key_lat, input key_lon, output ready);
endinterface

interface lrukc_res_if import lrukc_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    hit;
    logic [SLOT_W-1:0]       slot;
    logic                    evicted;
    logic signed [LAT_W-1:0] evicted_lat;
    logic signed [LON_W-1:0] evicted_lon;
    logic [MISS_W-1:0]       miss_total;

    modport source (output valid, output hit, output slot, output evicted,
                    output evicted_lat, output evicted_lon, output miss_total,
                    input ready);
    modport sink   (input valid, input hit, input slot, input evicted,
                    input evicted_lat, input evicted_lon, input miss_total,
                    output ready);
endinterface

interface lrukc_cfg_if import lrukc_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CAP_W-1:0] capacity;

    modport source (output valid, output capacity, input ready);
    modport sink   (input valid, input capacity, output ready);
endinterface

// ===== rtl/lrukc_cell.sv =====
`timescale 1ns / 1ps

module lrukc_cell import lrukc_pkg::*;
(
    input  logic              clk,
    input  logic [SLOT_W-1:0] cell_idx,
    input  look_t             look,
    input  upd_t              upd,
    input  chain_t            chain_in,
    output chain_t            chain_out
);

    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LON_W-1:0] lon_reg;
    logic [RANK_W-1:0]       rank_reg;
    logic                    occupied;
    logic                    match;
    logic                    victim;
    logic                    sel;

    assign occupied = FILL_W'(cell_idx) < look.fill;
    assign match    = occupied && (lat_reg == look.lat) && (lon_reg == look.lon);
    // ranks form a permutation, so exactly one occupied cell holds the oldest
    assign victim   = occupied && (rank_reg == look.last_rank);
    assign sel      = (cell_idx == upd.slot);

    always_comb
    begin
        chain_out          = chain_in;
        chain_out.hit      = chain_in.hit | match;
        chain_out.hit_slot = chain_in.hit_slot | (match ? cell_idx : '0);
        chain_out.hit_rank = chain_in.hit_rank | (match ? rank_reg : '0);
        chain_out.vic_slot = chain_in.vic_slot | (victim ? cell_idx : '0);
        chain_out.vic_lat  = chain_in.vic_lat | (victim ? lat_reg : '0);
        chain_out.vic_lon  = chain_in.vic_lon | (victim ? lon_reg : '0);
    end

    always_ff @(posedge clk)
    begin
        if (upd.en)
        begin
            if (sel)
            begin
                rank_reg <= '0;
                if (upd.write)
                begin
                    lat_reg <= upd.lat;
                    lon_reg <= upd.lon;
                end
            end
            else if (occupied && (rank_reg < upd.old_rank))
            begin
                rank_reg <= rank_reg + RANK_W'(1);
            end
        end
    end

endmodule

// ===== rtl/lru_tile_key_cache.sv =====
`timescale 1ns / 1ps

// Channel | Dir | Payload
// key     | in  | key_lat[7:0] signed, key_lon[8:0] signed
// res     | out | hit, slot[3:0], evicted, evicted_lat, evicted_lon, miss_total[31:0]
// cfg     | in  | capacity[4:0]
//
// Per key, accept registers the key, then the lookup state runs the tag
// compare across the cell row and commits the recency update.
// A new key is taken while the previous result waits in the output register.
// If that register is still full, the lookup holds until res is taken.
// Reset empties the store, clears the miss count and sets capacity to 16.
module lru_tile_key_cache import lrukc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    lrukc_key_if.sink    key,
    lrukc_res_if.source  res,
    lrukc_cfg_if.sink    cfg
);

    state_t                  state_reg, state_next;
    logic signed [LAT_W-1:0] lat_reg;
    logic signed [LON_W-1:0] lon_reg;
    logic [CAP_W-1:0]        cap_reg;
    logic [FILL_W-1:0]       fill_reg, fill_next;
    logic [MISS_W-1:0]       miss_reg, miss_next;
    logic                    res_valid_reg;

    logic                    hit_reg;
    logic [SLOT_W-1:0]       slot_reg;
    logic                    evicted_reg;
    logic signed [LAT_W-1:0] ev_lat_reg;
    logic signed [LON_W-1:0] ev_lon_reg;

    look_t                   look;
    upd_t                    upd;
    chain_t                  chain [ENTRIES+1];
    chain_t                  tail;
    logic [FILL_W-1:0]       eff_cap;
    logic                    finish;
    logic                    evict;
    logic [SLOT_W-1:0]       slot_sel;

    assign key.ready = (state_reg == ST_IDLE);
    assign cfg.ready = 1'b1;

    assign look.lat       = lat_reg;
    assign look.lon       = lon_reg;
    assign look.fill      = fill_reg;
    assign look.last_rank = RANK_W'(fill_reg - FILL_W'(1));

    assign chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < ENTRIES; gi++)
        begin : g_cell
            lrukc_cell u_cell (
                .clk       (clk),
                .cell_idx  (SLOT_W'(gi)),
                .look      (look),
                .upd       (upd),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1])
            );
        end
    endgenerate

    assign tail = chain[ENTRIES];

    always_comb
    begin
        if (cap_reg == '0)
            eff_cap = FILL_W'(1);
        else if (32'(cap_reg) > ENTRIES)
            eff_cap = FILL_W'(ENTRIES);
        else
            eff_cap = FILL_W'(cap_reg);
    end

    assign finish = (state_reg == ST_LOOK) && (!res_valid_reg || res.ready);
    assign evict  = !tail.hit && (fill_reg >= eff_cap) && (fill_reg != '0);

    always_comb
    begin
        if (tail.hit)
            slot_sel = tail.hit_slot;
        else if (evict)
            slot_sel = tail.vic_slot;
        else
            slot_sel = SLOT_W'(fill_reg);

        upd.en    = finish;
        upd.write = !tail.hit;
        upd.slot  = slot_sel;
        upd.lat   = lat_reg;
        upd.lon   = lon_reg;
        if (tail.hit)
            upd.old_rank = tail.hit_rank;
        else if (evict)
            upd.old_rank = look.last_rank;
        else
            upd.old_rank = RANK_W'(fill_reg);

        fill_next = fill_reg;
        miss_next = miss_reg;
        if (!tail.hit)
        begin
            miss_next = miss_reg + MISS_W'(1);
            if (!evict)
                fill_next = fill_reg + FILL_W'(1);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (key.valid)
                    state_next = ST_LOOK;
            end
            ST_LOOK:
            begin
                if (finish)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cap_reg       <= CAP_RESET;
            fill_reg      <= '0;
            miss_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid)
                cap_reg <= cfg.capacity;
            if (finish)
            begin
                fill_reg      <= fill_next;
                miss_reg      <= miss_next;
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (key.valid && key.ready)
        begin
            lat_reg <= key.key_lat;
            lon_reg <= key.key_lon;
        end
        if (finish)
        begin
            hit_reg     <= tail.hit;
            slot_reg    <= slot_sel;
            evicted_reg <= evict;
            ev_lat_reg  <= evict ? tail.vic_lat : '0;
            ev_lon_reg  <= evict ? tail.vic_lon : '0;
        end
    end

    assign res.valid       = res_valid_reg;
    assign res.hit         = hit_reg;
    assign res.slot        = slot_reg;
    assign res.evicted     = evicted_reg;
    assign res.evicted_lat = ev_lat_reg;
    assign res.evicted_lon = ev_lon_reg;
    assign res.miss_total  = miss_reg;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import lrukc_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RAND_PHASES   = 6;
    localparam int PHASE_ITEMS   = 125;
    localparam int POOL_MAX      = 32;

    typedef struct {
        logic [LAT_W-1:0] lat;
        logic [LON_W-1:0] lon;
    } tile_key_t;

    typedef struct {
        logic              hit;
        logic [SLOT_W-1:0] slot;
        logic              evicted;
        logic [LAT_W-1:0]  ev_lat;
        logic [LON_W-1:0]  ev_lon;
        logic [MISS_W-1:0] miss_total;
    } lookup_result_t;

    logic clk;
    logic rst_n;

    lrukc_key_if key_ch ();
    lrukc_res_if res_ch ();
    lrukc_cfg_if cfg_ch ();

    lru_tile_key_cache u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .key   (key_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    // predicted tag store
    logic [LAT_W-1:0]  tag_lat [ENTRIES];
    logic [LON_W-1:0]  tag_lon [ENTRIES];
    int                tag_rank [ENTRIES];
    int                fill_level   = 0;
    logic [MISS_W-1:0] miss_count   = '0;
    logic [CAP_W-1:0]  capacity_reg = CAP_RESET;

    tile_key_t      key_queue [$];
    lookup_result_t lookup_queue [$];

    int  send_idle = 34;
    int  recv_idle = 77;
    bit  key_moved = 0;
    int  stall_cycles = 0;
    int  errors = 0;
    int  lookups = 0;
    int  hits = 0;
    int  evictions = 0;
    int  cap_writes = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // entries more recent than old_rank age by one, slot becomes newest
    function automatic void make_newest(int slot, int old_rank);
        for (int i = 0; i < fill_level; i++)
        begin
            if (tag_rank[i] < old_rank)
                tag_rank[i]++;
        end
        tag_rank[slot] = 0;
    endfunction

    function automatic lookup_result_t lookup_tile(tile_key_t k);
        lookup_result_t r;
        int eff;
        int s;
        int victim_rank;
        r = '{default: 0};
        s = 0;
        eff = capacity_reg;
        if (eff < 1)
            eff = 1;
        if (eff > ENTRIES)
            eff = ENTRIES;
        for (int i = 0; i < fill_level; i++)
        begin
            if (!r.hit && tag_lat[i] == k.lat && tag_lon[i] == k.lon)
            begin
                r.hit = 1'b1;
                s = i;
            end
        end
        if (r.hit)
            make_newest(s, tag_rank[s]);
        else
        begin
            if (fill_level >= eff)
            begin
                victim_rank = 0;
                for (int i = 0; i < fill_level; i++)
                begin
                    if (tag_rank[i] >= victim_rank)
                    begin
                        victim_rank = tag_rank[i];
                        s = i;
                    end
                end
                r.evicted = 1'b1;
                r.ev_lat  = tag_lat[s];
                r.ev_lon  = tag_lon[s];
                tag_lat[s] = k.lat;
                tag_lon[s] = k.lon;
                make_newest(s, victim_rank);
            end
            else
            begin
                s = fill_level;
                tag_lat[s]  = k.lat;
                tag_lon[s]  = k.lon;
                tag_rank[s] = fill_level;
                fill_level++;
                make_newest(s, s);
            end
            miss_count = miss_count + 1'b1;
        end
        r.slot = SLOT_W'(s);
        r.miss_total = miss_count;
        return r;
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
        end
    endfunction

    function automatic tile_key_t random_key();
        tile_key_t k;
        int v;
        if ($urandom_range(99) < 75)
        begin
            v = int'($urandom_range(179)) - 90;
            k.lat = LAT_W'(v);
            v = int'($urandom_range(359)) - 180;
            k.lon = LON_W'(v);
        end
        else
        begin
            // raw patterns, out-of-range values included
            k.lat = LAT_W'($urandom);
            k.lon = LON_W'($urandom);
        end
        return k;
    endfunction

    task automatic queue_key(int lat, int lon);
        tile_key_t k;
        k.lat = LAT_W'(lat);
        k.lon = LON_W'(lon);
        key_queue = {key_queue, k};
    endtask

    task automatic queue_random_keys(int count, int pool_n);
        tile_key_t pool [POOL_MAX];
        for (int i = 0; i < pool_n; i++)
            pool[i] = random_key();
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 85)
                key_queue = {key_queue, pool[$urandom_range(pool_n - 1)]};
            else
                key_queue = {key_queue, random_key()};
        end
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid    <= 1'b1;
        cfg_ch.capacity <= value;
        do
            @(posedge clk);
        while (!(cfg_ch.valid && cfg_ch.ready));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (key_queue.size() > 0 || lookup_queue.size() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // key driver
    always @(negedge clk)
    begin
        if (!rst_n)
            key_ch.valid <= 1'b0;
        else if (!key_ch.valid || key_moved)
        begin
            if (key_queue.size() > 0 && $urandom_range(99) >= send_idle)
            begin
                key_ch.valid   <= 1'b1;
                key_ch.key_lat <= key_queue[0].lat;
                key_ch.key_lon <= key_queue[0].lon;
            end
            else
                key_ch.valid <= 1'b0;
        end
    end

    // result receiver
    always @(negedge clk)
    begin
        res_ch.ready <= ($urandom_range(99) >= recv_idle);
    end

    // monitor, predictor and watchdog
    always @(posedge clk)
    begin
        lookup_result_t want;
        tile_key_t seen;
        bit moved;
        if (!rst_n)
        begin
            key_moved = 1'b0;
            stall_cycles = 0;
        end
        else
        begin
            key_moved = key_ch.valid && key_ch.ready;
            moved = key_moved;
            if (res_ch.valid && res_ch.ready)
            begin
                moved = 1'b1;
                if (lookup_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, slot %0d miss_total %0d",
                             $time, res_ch.slot, res_ch.miss_total);
                end
                else
                begin
                    want = lookup_queue.pop_front();
                    check_field("hit", want.hit, res_ch.hit);
                    check_field("slot", want.slot, res_ch.slot);
                    check_field("evicted", want.evicted, res_ch.evicted);
                    check_field("evicted_lat", want.ev_lat,
                                unsigned'(res_ch.evicted_lat));
                    check_field("evicted_lon", want.ev_lon,
                                unsigned'(res_ch.evicted_lon));
                    check_field("miss_total", want.miss_total, res_ch.miss_total);
                end
            end
            if (cfg_ch.valid && cfg_ch.ready)
            begin
                moved = 1'b1;
                capacity_reg = cfg_ch.capacity;
                cap_writes++;
            end
            if (key_moved)
            begin
                seen.lat = key_ch.key_lat;
                seen.lon = key_ch.key_lon;
                void'(key_queue.pop_front());
                want = lookup_tile(seen);
                lookups++;
                hits += want.hit;
                evictions += want.evicted;
                lookup_queue = {lookup_queue, want};
            end
            if (moved)
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t ns: no item moved for %0d cycles, %0d keys and %0d results pending",
                         $time, STALL_LIMIT, key_queue.size(), lookup_queue.size());
                $display("lru_tile_key_cache test failed");
                $finish;
            end
        end
    end

    initial
    begin
        int phase_cap [RAND_PHASES]  = '{16, 1, 5, 31, 3, 12};
        int phase_pool [RAND_PHASES] = '{22, 3, 9, 20, 6, 16};
        rst_n           = 1'b0;
        key_ch.valid    = 1'b0;
        key_ch.key_lat  = '0;
        key_ch.key_lon  = '0;
        res_ch.ready    = 1'b0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.capacity = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // two entries: field extremes, hits promoting, LRU eviction order
        write_capacity(CAP_W'(2));
        queue_key(-90, -180);
        queue_key(89, 179);
        queue_key(-90, -180);
        queue_key(-128, -256);
        queue_key(-90, -180);
        queue_key(127, 255);
        queue_key(127, 255);
        queue_key(0, 0);
        wait_drained();

        // zero acts as one, and is below the fill count
        write_capacity(CAP_W'(0));
        queue_key(1, -1);
        queue_key(1, -1);
        queue_key(-1, 1);
        queue_key(0, 0);
        wait_drained();

        // above the store size: clamps to full size, store grows again
        write_capacity(CAP_W'(31));
        queue_key(45, 90);
        queue_key(-45, -90);
        queue_key(12, 34);
        queue_key(-128, 255);
        queue_key(127, -256);
        queue_key(45, 90);
        wait_drained();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 2)
            begin
                send_idle = 77;
                recv_idle = 34;
            end
            else if (p == 4)
            begin
                send_idle = 0;
                recv_idle = 0;
            end
            write_capacity(CAP_W'(phase_cap[p]));
            queue_random_keys(PHASE_ITEMS, phase_pool[p]);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Ran %0d lookups: %0d hits, %0d evictions, %0d misses counted",
                 lookups, hits, evictions, miss_count);
        $display("Capacity written %0d times, from zero up to the 5-bit maximum", cap_writes);
        if (errors == 0)
            $display("lru_tile_key_cache test passed");
        else
            $display("lru_tile_key_cache test failed");
        $finish;
    end

endmodule
